### src/sdp_pkg.sv
// Shared types, constants and the helper function of the step/direction pulser.
package sdp_pkg;

  localparam int DEG_W   = 24;
  localparam int COUNT_W = 25;
  localparam int TIMER_W = 20;
  localparam int NUM_W   = 41;
  localparam int DEN_W   = 28;
  localparam int PER_W   = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RPM        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HIGH_TENTHS = 2'd2;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  // The divisor 36000 is 32 * 1125; the remaining division by 1125 uses rounded-up
  // reciprocals ceil(2^s / 1125), exact for dividends below 2^(s - 11).
  localparam int                 CNT_SHIFT     = 5;
  localparam logic [19:0]        RECIP_TURN    = 20'd954438;
  localparam int                 RECIP_TURN_SH = 30;
  localparam logic [27:0]        RECIP_REST    = 28'd244335918;
  localparam int                 RECIP_REST_SH = 38;
  localparam logic [15:0]        DEG_DIVISOR   = 16'd36000;
  localparam logic [31:0]        DEG_HALF      = 32'd18000;
  localparam logic [NUM_W-1:0]   US_PER_MIN    = 41'd60000000;
  localparam logic [COUNT_W:0]   COUNT_MAX     = 26'h1FFFFFF;
  localparam logic [PER_W-1:0]   TIMER_MAX     = 26'hFFFFF;

  localparam logic [15:0] PPR_RESET  = 16'd400;
  localparam logic [11:0] RPM_RESET  = 12'd600;
  localparam logic [5:0]  HIGH_RESET = 6'd25;

  typedef struct packed {
    logic              func;
    logic              direction;
    logic [DEG_W-1:0]  degree_centi;
  } in_t;

  typedef struct packed {
    logic               dir_level;
    logic               pulse_level;
    logic               busy_res;
    logic               rejected;
    logic [COUNT_W-1:0] pulses_left;
  } out_t;

  typedef struct packed {
    logic step_tick;
    logic step_reject;
    logic latch_move;
    logic mul;
    logic div_start;
    logic div_sel_period;
    logic take_count;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic prod_zero;
    logic div_done;
  } sts_t;

  // Floor of x / 10 for any 7-bit x; the multiply-and-shift is exact for x below 1029.
  function automatic logic [3:0] div10(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:11];
  endfunction

endpackage

### src/sdp_div.sv
// Restoring serial divider producing one quotient bit per cycle.
module sdp_div import sdp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial  = {rem_q, num_q[NUM_W-1]};
    fits   = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W - 1);
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

### src/sdp_dp.sv
// Datapath: configuration registers, move arithmetic, pulse timing and result register.
module sdp_dp import sdp_pkg::*; #(
  parameter int SETTLE_TICKS = 10,
  parameter int ANGLE_BITS   = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_t                   in_data_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output out_t                  out_data_o
);

  localparam int AngleKeep = (ANGLE_BITS < DEG_W) ? ANGLE_BITS : DEG_W;
  localparam logic [DEG_W-1:0] AngleMask = DEG_W'((64'd1 << AngleKeep) - 64'd1);
  localparam int TurnsW = 9;
  localparam int RestW  = 32;
  localparam int RestQW = 17;
  localparam int SumW   = COUNT_W + 1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_HIGH   = 2'd2,
    PH_LOW    = 2'd3
  } phase_e;

  logic [15:0]        ppr_q, ppr_d;
  logic [11:0]        rpm_q, rpm_d;
  logic [5:0]         high_q, high_d;
  logic               dir_q, dir_d;
  logic               pulse_q, pulse_d;
  phase_e             phase_q, phase_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [TIMER_W-1:0] low_q, low_d;

  logic [DEG_W-1:0]   angle_q, angle_d;
  logic [DEN_W-1:0]   prod_q, prod_d;
  logic [COUNT_W-1:0] pulses_q, pulses_d;
  out_t               out_q, out_d;

  logic [3:0]         cnt_v_q, cnt_v_d;
  logic [TurnsW-1:0]  turns_q, turns_d;
  logic [15:0]        frac_q, frac_d;
  logic [COUNT_W-1:0] whole_q, whole_d;
  logic [RestW-1:0]   rest_q, rest_d;
  logic [RestQW-1:0]  rest_div_q, rest_div_d;
  logic [38:0]        turns_prod;
  logic [54:0]        rest_prod;
  logic [SumW-1:0]    cnt_sum;
  logic               cnt_go;
  logic               per_go;

  logic               div_done;
  logic [NUM_W-1:0]   div_quot;

  logic [3:0]         high_floor, high_ceil, high_round;
  logic [TIMER_W-1:0] high_ticks, timer_dec;
  logic [PER_W-1:0]   period, period_fix, low_full;
  logic [TIMER_W-1:0] low_sat;

  assign cnt_go = cmd_i.div_start && !cmd_i.div_sel_period;
  assign per_go = cmd_i.div_start && cmd_i.div_sel_period;

  sdp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (per_go),
    .num_i   (US_PER_MIN),
    .den_i   (prod_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Pulse count pipeline: whole turns times ppr plus the rounded share of the remainder.
  assign turns_prod = 39'(angle_q[DEG_W-1:CNT_SHIFT]) * 39'(RECIP_TURN);
  assign turns_d    = turns_prod[RECIP_TURN_SH +: TurnsW];
  assign frac_d     = 16'(angle_q - DEG_W'(turns_q) * DEG_W'(DEG_DIVISOR));
  assign whole_d    = COUNT_W'(turns_q) * COUNT_W'(ppr_q);
  assign rest_d     = RestW'(frac_q) * RestW'(ppr_q) + DEG_HALF;
  assign rest_prod  = 55'(rest_q[RestW-1:CNT_SHIFT]) * 55'(RECIP_REST);
  assign rest_div_d = rest_prod[RECIP_REST_SH +: RestQW];
  assign cnt_sum    = SumW'(whole_q) + SumW'(rest_div_q);
  assign cnt_v_d    = {cnt_v_q[2:0], cnt_go};

  assign high_floor = div10({1'b0, high_q});
  assign high_ceil  = div10(7'(high_q) + 7'd9);
  assign high_round = div10(7'(high_q) + 7'd5);
  assign high_ticks = (high_round == '0) ? TIMER_W'(1) : TIMER_W'(high_round);
  assign timer_dec  = (timer_q != '0) ? timer_q - 1'b1 : '0;

  assign period     = div_quot[PER_W-1:0];
  assign period_fix = (period <= PER_W'(high_floor) + PER_W'(1)) ?
                      PER_W'(high_floor) + PER_W'(2) : period;
  assign low_full   = period_fix - PER_W'(high_ceil);
  assign low_sat    = (low_full > TIMER_MAX) ? TIMER_MAX[TIMER_W-1:0] : low_full[TIMER_W-1:0];

  always_comb begin
    ppr_d    = ppr_q;
    rpm_d    = rpm_q;
    high_d   = high_q;
    dir_d    = dir_q;
    pulse_d  = pulse_q;
    phase_d  = phase_q;
    timer_d  = timer_q;
    count_d  = count_q;
    low_d    = low_q;
    angle_d  = angle_q;
    prod_d   = prod_q;
    pulses_d = pulses_q;
    out_d    = out_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PULSES_PER_REV:    ppr_d  = cfg_data_i;
        CFG_TARGET_RPM:        rpm_d  = cfg_data_i[11:0];
        CFG_PULSE_HIGH_TENTHS: high_d = cfg_data_i[5:0];
        default: ;
      endcase
    end

    if (cmd_i.latch_move) begin
      angle_d = in_data_i.degree_centi & AngleMask;
      dir_d   = in_data_i.direction;
    end
    if (cmd_i.mul) begin
      prod_d = DEN_W'(rpm_q) * DEN_W'(ppr_q);
    end
    if (cmd_i.take_count) begin
      pulses_d = (cnt_sum > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : cnt_sum[COUNT_W-1:0];
    end
    if (cmd_i.finish) begin
      pulse_d = 1'b0;
      count_d = pulses_q;
      low_d   = low_sat;
      phase_d = PH_SETTLE;
      timer_d = TIMER_W'(SETTLE_TICKS);
    end

    if (cmd_i.step_tick && (phase_q != PH_IDLE)) begin
      timer_d = timer_dec;
      if (timer_dec == '0) begin
        case (phase_q)
          PH_SETTLE: begin
            if (count_q == '0) begin
              phase_d = PH_IDLE;
            end else begin
              pulse_d = 1'b1;
              phase_d = PH_HIGH;
              timer_d = high_ticks;
            end
          end
          PH_HIGH: begin
            pulse_d = 1'b0;
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
            end
            phase_d = PH_LOW;
            timer_d = (low_q == '0) ? TIMER_W'(1) : low_q;
          end
          PH_LOW: begin
            if (count_q != '0) begin
              pulse_d = 1'b1;
              phase_d = PH_HIGH;
              timer_d = high_ticks;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
    end

    if (cmd_i.step_tick || cmd_i.step_reject || cmd_i.finish) begin
      out_d.dir_level   = dir_d;
      out_d.pulse_level = pulse_d;
      out_d.busy_res    = phase_d != PH_IDLE;
      out_d.rejected    = cmd_i.step_reject;
      out_d.pulses_left = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q   <= PPR_RESET;
      rpm_q   <= RPM_RESET;
      high_q  <= HIGH_RESET;
      dir_q   <= 1'b0;
      pulse_q <= 1'b0;
      phase_q <= PH_IDLE;
      timer_q <= '0;
      count_q <= '0;
      low_q   <= '0;
      cnt_v_q <= '0;
    end else begin
      ppr_q   <= ppr_d;
      rpm_q   <= rpm_d;
      high_q  <= high_d;
      dir_q   <= dir_d;
      pulse_q <= pulse_d;
      phase_q <= phase_d;
      timer_q <= timer_d;
      count_q <= count_d;
      low_q   <= low_d;
      cnt_v_q <= cnt_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q    <= angle_d;
    prod_q     <= prod_d;
    pulses_q   <= pulses_d;
    out_q      <= out_d;
    turns_q    <= turns_d;
    frac_q     <= frac_d;
    whole_q    <= whole_d;
    rest_q     <= rest_d;
    rest_div_q <= rest_div_d;
  end

  assign sts_o.busy      = phase_q != PH_IDLE;
  assign sts_o.prod_zero = (ppr_q == '0) || (rpm_q == '0);
  assign sts_o.div_done  = div_done || cnt_v_q[3];
  assign out_data_o      = out_q;

endmodule

### src/sdp_ctrl.sv
// Controller state machine sequencing ticks, move setup and result transfers.
module sdp_ctrl import sdp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_func_i,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_MUL      = 3'd1,
    S_CNT_GO   = 3'd2,
    S_CNT_WAIT = 3'd3,
    S_PER_GO   = 3'd4,
    S_PER_WAIT = 3'd5
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   refuse;

  assign in_stall_o = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept     = in_valid_i && !in_stall_o;
  assign refuse     = sts_i.busy || sts_i.prod_zero;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_func_i != FUNC_MOVE) begin
            cmd_o.step_tick = 1'b1;
            out_valid_d     = 1'b1;
          end else if (refuse) begin
            cmd_o.step_reject = 1'b1;
            out_valid_d       = 1'b1;
          end else begin
            cmd_o.latch_move = 1'b1;
            state_d          = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CNT_GO;
      end
      S_CNT_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_CNT_WAIT;
      end
      S_CNT_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.take_count = 1'b1;
          state_d          = S_PER_GO;
        end
      end
      S_PER_GO: begin
        cmd_o.div_start      = 1'b1;
        cmd_o.div_sel_period = 1'b1;
        state_d              = S_PER_WAIT;
      end
      S_PER_WAIT: begin
        cmd_o.div_sel_period = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/stepper_step_dir_pulser.sv
// Top level of the step/direction pulse generator.
// A tick or a refused move is answered in the cycle after its transfer; while the output
// is not stalled, one item per cycle is taken. An accepted move is answered after a
// multiply step, a four-stage pulse count pipeline and a serial divide for the period.
// One item is in work at a time; a new item is taken while the previous result is transferred.
// Reset is asynchronous and active low; it restores the default speed and pulse settings.
module stepper_step_dir_pulser import sdp_pkg::*; #(
  parameter int SETTLE_TICKS = 10,
  parameter int ANGLE_BITS   = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  sdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_data_i.func),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  sdp_dp #(
    .SETTLE_TICKS (SETTLE_TICKS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

### src/sdp_checker.sv
// Port-level checks of the pulse generator and their binding to the top level.
module sdp_checker import sdp_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input in_t                   in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_t                  out_data_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result is stalled");

  a_pulse_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pulse_level |-> out_data_o.busy_res)
    else $error("step pin high while idle");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.busy_res |-> out_data_o.pulses_left == '0)
    else $error("pulses left while idle");

endmodule

bind stepper_step_dir_pulser sdp_checker u_sdp_checker (.*);
